// ===== design/rabs_pkg.sv =====
// Package for the running-average background subtract unit.
// Types, field widths and fixed constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rabs_pkg;

    localparam int BYTE_W      = 8;
    localparam int PIX_IDX_W   = 19;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_SHIFT = 16;
    localparam int THR_W       = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_HALF = 17'd32768;
    localparam logic [THR_W-1:0]   THR_RESET  = 8'd10;

    // BT.601 weights, 14-bit fixed point
    localparam int GREY_W     = 22;
    localparam int GREY_SHIFT = 14;
    localparam logic [GREY_W-1:0] GREY_WB    = 22'd1868;
    localparam logic [GREY_W-1:0] GREY_WG    = 22'd9617;
    localparam logic [GREY_W-1:0] GREY_WR    = 22'd4899;
    localparam logic [GREY_W-1:0] GREY_ROUND = 22'd8192;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_LEVEL = 1'd1;

    typedef struct packed {
        logic [BYTE_W-1:0]    grey;
        logic [PIX_IDX_W-1:0] index;
        logic                 frame_end;
        logic                 learn;
    } t_item;

    typedef struct packed {
        logic                 is_foreground;
        logic [PIX_IDX_W-1:0] index;
        logic                 frame_end;
    } t_result;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic [THR_W-1:0]   threshold;
    } t_cfg;

endpackage

`default_nettype wire

// ===== design/rabs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rabs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 524288
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/rabs_fifo.sv =====
// Small register FIFO with fill count, power-of-two depth.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rabs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_empty,
    output logic                            o_full,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/rabs_front.sv =====
// Front end: takes pixel transfers, weighs the colour bytes, tags learning-phase items.
// Depends on rabs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rabs_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire logic [rabs_pkg::BYTE_W-1:0]    i_blue,
    input  wire logic [rabs_pkg::BYTE_W-1:0]    i_green,
    input  wire logic [rabs_pkg::BYTE_W-1:0]    i_red,
    input  wire logic [rabs_pkg::PIX_IDX_W-1:0] i_pixel_index,
    input  wire logic                           i_frame_end,
    input  wire logic                           i_queue_full,
    output logic                                o_push,
    output rabs_pkg::t_item                     o_item
);

    localparam int GW = rabs_pkg::GREY_W;

    logic                           r_valid;
    logic                           r_bg_ready;
    logic [GW-1:0]                  r_bw;
    logic [GW-1:0]                  r_gw;
    logic [GW-1:0]                  r_rw;
    logic [rabs_pkg::PIX_IDX_W-1:0] r_index;
    logic                           r_frame_end;
    logic                           r_learn;
    logic                           w_accept;
    logic [GW-1:0]                  w_sum;

    assign o_full   = r_valid && i_queue_full;
    assign o_push   = r_valid && !i_queue_full;
    assign w_accept = i_push && !o_full;

    assign w_sum = r_bw + r_gw + r_rw + rabs_pkg::GREY_ROUND;

    assign o_item.grey      = w_sum[GW-1:rabs_pkg::GREY_SHIFT];
    assign o_item.index     = r_index;
    assign o_item.frame_end = r_frame_end;
    assign o_item.learn     = r_learn;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bw        <= GW'(i_blue) * rabs_pkg::GREY_WB;
            r_gw        <= GW'(i_green) * rabs_pkg::GREY_WG;
            r_rw        <= GW'(i_red) * rabs_pkg::GREY_WR;
            r_index     <= i_pixel_index;
            r_frame_end <= i_frame_end;
            r_learn     <= !r_bg_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_bg_ready <= 1'b0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
            if (w_accept && i_frame_end) begin
                r_bg_ready <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/rabs_back.sv =====
// Back end: background lookup, foreground test, running-average update, result queue.
// Depends on rabs_pkg, rabs_ram, rabs_fifo.
`timescale 1ns / 1ps
`default_nettype none

module rabs_back #(
    parameter int INDEX_BITS    = 19,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire rabs_pkg::t_cfg    i_cfg,
    input  wire rabs_pkg::t_item   i_item,
    input  wire logic     i_item_valid,
    output logic          o_item_pop,
    output rabs_pkg::t_result o_result,
    output logic          o_empty,
    input  wire logic     i_pop
);

    localparam int SW    = rabs_pkg::BYTE_W + FRACTION_BITS;
    localparam int PW    = SW + rabs_pkg::ALPHA_W;
    localparam int EXT_W = (INDEX_BITS > rabs_pkg::PIX_IDX_W) ? INDEX_BITS
                                                               : rabs_pkg::PIX_IDX_W;
    localparam int OCW   = $clog2(rabs_pkg::OUT_DEPTH + 1);
    localparam int RW    = $bits(rabs_pkg::t_result);
    localparam logic [FRACTION_BITS-1:0] HALF_LSB = {1'b1, {(FRACTION_BITS-1){1'b0}}};

    // issue
    logic [EXT_W-1:0]      w_idx_ext;
    logic [INDEX_BITS-1:0] w_slot;
    logic                  w_hazard;
    logic                  w_credit;
    logic                  w_issue;
    logic [OCW:0]          w_in_use;
    logic [OCW-1:0]        w_out_count;

    // stage 2
    logic                  r_s2_v;
    rabs_pkg::t_item       r_s2_item;
    logic [INDEX_BITS-1:0] r_s2_slot;
    logic [SW-1:0]         w_bg;
    logic [SW-1:0]         w_grey_fx;
    logic [rabs_pkg::BYTE_W-1:0] w_whole;
    logic [FRACTION_BITS-1:0]    w_rem;
    logic                  w_round_up;
    logic [rabs_pkg::BYTE_W:0]   w_bg8;
    logic [rabs_pkg::BYTE_W:0]   w_grey9;
    logic [rabs_pkg::BYTE_W:0]   w_diff;
    logic                  w_fg;
    logic                  w_up;
    logic [SW-1:0]         w_mag;

    // stage 3
    logic                  r_s3_v;
    rabs_pkg::t_result     r_s3_res;
    logic [INDEX_BITS-1:0] r_s3_slot;
    logic                  r_s3_wr;
    logic                  r_s3_learn;
    logic                  r_s3_up;
    logic [SW-1:0]         r_s3_mag;
    logic [SW-1:0]         r_s3_bg;
    logic [rabs_pkg::BYTE_W-1:0] r_s3_grey;
    logic [PW-1:0]         w_prod;

    // stage 4
    logic                  r_s4_v;
    rabs_pkg::t_result     r_s4_res;
    logic [INDEX_BITS-1:0] r_s4_slot;
    logic                  r_s4_wr;
    logic                  r_s4_learn;
    logic                  r_s4_up;
    logic [SW-1:0]         r_s4_step;
    logic [SW-1:0]         r_s4_bg;
    logic [rabs_pkg::BYTE_W-1:0] r_s4_grey;
    logic [SW-1:0]         w_new_bg;

    logic [RW-1:0]         w_out_data;

    assign w_idx_ext = EXT_W'(i_item.index);
    assign w_slot    = w_idx_ext[INDEX_BITS-1:0];

    // a read must wait until every older write to the same entry has landed
    assign w_hazard = !i_item.learn &&
                      ((r_s2_v && r_s2_slot == w_slot) ||
                       (r_s3_v && r_s3_slot == w_slot) ||
                       (r_s4_v && r_s4_slot == w_slot));

    assign w_in_use = (OCW+1)'(w_out_count) + (OCW+1)'(r_s2_v)
                    + (OCW+1)'(r_s3_v) + (OCW+1)'(r_s4_v);
    assign w_credit = w_in_use < (OCW+1)'(rabs_pkg::OUT_DEPTH);

    assign w_issue    = i_item_valid && !w_hazard && w_credit;
    assign o_item_pop = w_issue;

    rabs_ram #(
        .WIDTH (SW),
        .DEPTH (2 ** INDEX_BITS)
    ) u_bg_store (
        .i_clk     (i_clk),
        .i_wr_en   (r_s4_v && r_s4_wr),
        .i_wr_addr (r_s4_slot),
        .i_wr_data (w_new_bg),
        .i_rd_en   (w_issue && !i_item.learn),
        .i_rd_addr (w_slot),
        .o_rd_data (w_bg)
    );

    // stage 2: compare against rounded background
    assign w_grey_fx  = {r_s2_item.grey, {FRACTION_BITS{1'b0}}};
    assign w_whole    = w_bg[SW-1:FRACTION_BITS];
    assign w_rem      = w_bg[FRACTION_BITS-1:0];
    assign w_round_up = (w_rem > HALF_LSB) || (w_rem == HALF_LSB && w_whole[0]);
    assign w_bg8      = {1'b0, w_whole} + (rabs_pkg::BYTE_W+1)'(w_round_up);
    assign w_grey9    = {1'b0, r_s2_item.grey};
    assign w_diff     = (w_grey9 > w_bg8) ? (w_grey9 - w_bg8) : (w_bg8 - w_grey9);
    assign w_fg       = !r_s2_item.learn && (w_diff > {1'b0, i_cfg.threshold});
    assign w_up       = (w_grey_fx >= w_bg);
    assign w_mag      = w_up ? (w_grey_fx - w_bg) : (w_bg - w_grey_fx);

    // stage 3: scaled step, rounded half away from zero on the magnitude
    assign w_prod = PW'(r_s3_mag) * PW'(i_cfg.alpha) + PW'(rabs_pkg::ALPHA_HALF);

    // stage 4: new background value
    always_comb begin
        if (r_s4_learn) begin
            w_new_bg = {r_s4_grey, {FRACTION_BITS{1'b0}}};
        end else if (r_s4_up) begin
            w_new_bg = r_s4_bg + r_s4_step;
        end else begin
            w_new_bg = r_s4_bg - r_s4_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_s2_item <= i_item;
            r_s2_slot <= w_slot;
        end
        r_s3_res.is_foreground <= w_fg;
        r_s3_res.index         <= r_s2_item.index;
        r_s3_res.frame_end     <= r_s2_item.frame_end;
        r_s3_slot              <= r_s2_slot;
        r_s3_wr                <= r_s2_item.learn || w_fg;
        r_s3_learn             <= r_s2_item.learn;
        r_s3_up                <= w_up;
        r_s3_mag               <= w_mag;
        r_s3_bg                <= w_bg;
        r_s3_grey              <= r_s2_item.grey;
        r_s4_res               <= r_s3_res;
        r_s4_slot              <= r_s3_slot;
        r_s4_wr                <= r_s3_wr;
        r_s4_learn             <= r_s3_learn;
        r_s4_up                <= r_s3_up;
        r_s4_step              <= w_prod[rabs_pkg::ALPHA_SHIFT +: SW];
        r_s4_bg                <= r_s3_bg;
        r_s4_grey              <= r_s3_grey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s2_v <= w_issue;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    rabs_fifo #(
        .WIDTH (RW),
        .DEPTH (rabs_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s4_v),
        .i_data  (r_s4_res),
        .i_pop   (i_pop),
        .o_data  (w_out_data),
        .o_empty (o_empty),
        .o_full  (),
        .o_count (w_out_count)
    );

    assign o_result = rabs_pkg::t_result'(w_out_data);

endmodule

`default_nettype wire

// ===== design/running_average_background_subtract_unit.sv =====
// Path: front register, mid queue, back-end stages 2, 3 and 4, then the result queue.
// Throughput: one pixel per cycle while results are popped; a pixel whose background
// entry is still being updated by one of the three back-end pixels ahead of it waits.
// Reset: clears queues, pipeline, the first-frame flag and the registers to their
// defaults; the background store is not cleared and is filled by the first frame.
// Depends on rabs_pkg, rabs_front, rabs_fifo, rabs_back.
`timescale 1ns / 1ps
`default_nettype none

module running_average_background_subtract_unit #(
    parameter int INDEX_BITS    = 19,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic [rabs_pkg::BYTE_W-1:0]       i_blue,
    input  wire logic [rabs_pkg::BYTE_W-1:0]       i_green,
    input  wire logic [rabs_pkg::BYTE_W-1:0]       i_red,
    input  wire logic [rabs_pkg::PIX_IDX_W-1:0]    i_pixel_index,
    input  wire logic                              i_frame_end,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic                                   o_is_foreground,
    output logic      [rabs_pkg::PIX_IDX_W-1:0]    o_out_index,
    output logic                                   o_out_frame_end,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [rabs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rabs_pkg::ALPHA_W-1:0]      i_cfg_data
);

    localparam int IW = $bits(rabs_pkg::t_item);

    logic [rabs_pkg::ALPHA_W-1:0] r_alpha;
    logic [rabs_pkg::THR_W-1:0]   r_threshold;
    rabs_pkg::t_cfg               w_cfg;

    logic                         w_mid_push;
    logic                         w_mid_full;
    logic                         w_mid_empty;
    logic                         w_mid_pop;
    rabs_pkg::t_item              w_front_item;
    logic [IW-1:0]                w_mid_data;
    rabs_pkg::t_result            w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= rabs_pkg::ALPHA_ONE;
            r_threshold <= rabs_pkg::THR_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rabs_pkg::CFG_LEARNING_RATE: begin
                    r_alpha <= (i_cfg_data > rabs_pkg::ALPHA_ONE) ? rabs_pkg::ALPHA_ONE
                                                                  : i_cfg_data;
                end
                rabs_pkg::CFG_THRESHOLD_LEVEL: begin
                    r_threshold <= i_cfg_data[rabs_pkg::THR_W-1:0];
                end
                default: begin
                    r_alpha <= r_alpha;
                end
            endcase
        end
    end

    assign w_cfg.alpha     = r_alpha;
    assign w_cfg.threshold = r_threshold;

    rabs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_blue        (i_blue),
        .i_green       (i_green),
        .i_red         (i_red),
        .i_pixel_index (i_pixel_index),
        .i_frame_end   (i_frame_end),
        .i_queue_full  (w_mid_full),
        .o_push        (w_mid_push),
        .o_item        (w_front_item)
    );

    rabs_fifo #(
        .WIDTH (IW),
        .DEPTH (rabs_pkg::MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_front_item),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_full  (w_mid_full),
        .o_count ()
    );

    rabs_back #(
        .INDEX_BITS    (INDEX_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item       (rabs_pkg::t_item'(w_mid_data)),
        .i_item_valid (!w_mid_empty),
        .o_item_pop   (w_mid_pop),
        .o_result     (w_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_is_foreground = w_result.is_foreground;
    assign o_out_index     = w_result.index;
    assign o_out_frame_end = w_result.frame_end;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mid_push && w_mid_full))
        else $error("front pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mid_pop && w_mid_empty))
        else $error("back popped an empty queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_full_needs_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_mid_full && !w_mid_push))
        else $error("input stalled while the queue had room");

endmodule

`default_nettype wire
